// ===== sv/edbd_pkg.sv =====
package edbd_pkg;

    // Line width register
    localparam int LW_W = 10;
    localparam logic [LW_W-1:0] LW_RESET = 10'd512;

    // Pixel and error widths
    localparam int PIX_W = 8;
    localparam int ERR_W = 12;

    typedef logic signed [ERR_W-1:0] t_err;

    // Row role: top row, or which line buffer the current row writes
    typedef enum logic [1:0] {
        PH_TOP,
        PH_A,
        PH_B
    } t_phase;

    // Control and payload of the word held between the sequencer and the datapath
    typedef struct packed {
        logic             valid;
        logic             start;
        logic             last;
        logic             rewind;   // column clamped back by a lowered width
        t_phase           phase;
        logic [PIX_W-1:0] pix;
    } t_s1_ctl;

endpackage

// ===== sv/edbd_lmem.sv =====
module edbd_lmem #(
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  edbd_pkg::t_err i_wdata,
    input  logic           i_re,
    input  logic [AW-1:0]  i_raddr0,
    input  logic [AW-1:0]  i_raddr1,
    output edbd_pkg::t_err o_rdata0,
    output edbd_pkg::t_err o_rdata1
);
    import edbd_pkg::*;

    t_err r_mem [DEPTH];
    t_err r_rdata0;
    t_err r_rdata1;

    // One write port, two registered read ports; a read of the entry being
    // written in the same cycle returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata0 <= (i_we && (i_waddr == i_raddr0)) ? i_wdata : r_mem[i_raddr0];
            r_rdata1 <= (i_we && (i_waddr == i_raddr1)) ? i_wdata : r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== sv/edbd_seq.sv =====
module edbd_seq #(
    parameter int MAX_WIDTH = 512,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [edbd_pkg::PIX_W-1:0] i_gray_level,
    input  logic                      i_start_of_image,
    input  logic                      i_cfg_wr_en,
    input  logic [edbd_pkg::LW_W-1:0] i_cfg_wr_data,
    input  logic                      i_take,
    output edbd_pkg::t_s1_ctl         o_s1,
    output logic [CW-1:0]             o_s1_col,
    output logic                      o_rd_en,
    output logic [CW-1:0]             o_raddr0,
    output logic [CW-1:0]             o_raddr1
);
    import edbd_pkg::*;

    localparam int EW = (WW > LW_W) ? WW : LW_W;

    logic [LW_W-1:0] r_line_width;
    logic [CW-1:0]   r_col;
    logic [CW-1:0]   n_col;
    t_phase          r_phase;
    t_phase          n_phase;
    t_s1_ctl         r_s1;
    logic [CW-1:0]   r_s1_col;

    logic            accept;
    t_phase          phase_eff;
    logic [CW-1:0]   col_eff;
    logic [EW-1:0]   lw_ext;
    logic [WW-1:0]   w_eff;
    logic [WW-1:0]   w_m1;
    logic            last;
    logic            rewind;
    logic [CW-1:0]   col;

    assign o_in_ready = !r_s1.valid || i_take;
    assign accept     = i_in_valid && o_in_ready;

    // Image start restarts the top row at column zero
    assign phase_eff = i_start_of_image ? PH_TOP : r_phase;
    assign col_eff   = i_start_of_image ? '0 : r_col;

    // Effective width: zero acts as one, clamp at the buffer size
    assign lw_ext = EW'(r_line_width);
    always_comb begin
        if (r_line_width == '0) begin
            w_eff = WW'(1);
        end else if (lw_ext > EW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = lw_ext[WW-1:0];
        end
    end
    assign w_m1   = w_eff - WW'(1);
    assign last   = WW'(col_eff) >= w_m1;
    assign rewind = WW'(col_eff) > w_m1;
    assign col    = last ? w_m1[CW-1:0] : col_eff;

    // Column counter
    assign n_col = !accept ? r_col : (last ? '0 : col + CW'(1));

    // Row phase: top row, then rows alternate between the two buffers
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            n_phase = phase_eff;
            if (last) begin
                unique case (phase_eff)
                    PH_TOP:  n_phase = PH_A;
                    PH_A:    n_phase = PH_B;
                    PH_B:    n_phase = PH_A;
                    default: n_phase = PH_TOP;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOP;
            r_col   <= '0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
        end
    end

    // Line width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_width <= i_cfg_wr_data;
        end
    end

    // Word register in front of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (accept) begin
            r_s1.valid <= 1'b1;
        end else if (i_take) begin
            r_s1.valid <= 1'b0;
        end
        if (accept) begin
            r_s1.start  <= i_start_of_image;
            r_s1.last   <= last;
            r_s1.rewind <= rewind;
            r_s1.phase  <= phase_eff;
            r_s1.pix    <= i_gray_level;
            r_s1_col    <= col;
        end
    end

    // Fetch above and above-right entries of the previous row; a clamped
    // column has no above-right and fetches its left neighbors instead
    assign o_rd_en  = accept;
    assign o_raddr0 = col;
    assign o_raddr1 = rewind ? (col - CW'(1)) : (col + CW'(1));

    assign o_s1     = r_s1;
    assign o_s1_col = r_s1_col;

endmodule

// ===== sv/edbd_core.sv =====
module edbd_core #(
    parameter int MAX_WIDTH = 512,
    localparam int CW = $clog2(MAX_WIDTH),
    localparam int WW = $clog2(MAX_WIDTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  edbd_pkg::t_s1_ctl i_s1,
    input  logic [CW-1:0]     i_s1_col,
    input  edbd_pkg::t_err    i_a_rdata0,
    input  edbd_pkg::t_err    i_a_rdata1,
    input  edbd_pkg::t_err    i_b_rdata0,
    input  edbd_pkg::t_err    i_b_rdata1,
    input  logic              i_out_ready,
    output logic              o_take,
    output logic              o_a_we,
    output logic              o_b_we,
    output logic [CW-1:0]     o_waddr,
    output edbd_pkg::t_err    o_wdata,
    output logic              o_out_valid,
    output logic              o_dark,
    output logic              o_end_of_row
);
    import edbd_pkg::*;

    typedef logic signed [15:0] t_sum;

    // Stage state, cleared at image start
    t_err             r_run;
    logic [WW-1:0]    r_fill_a;
    logic [WW-1:0]    r_fill_b;
    t_err             r_edge_a;
    t_err             r_edge_b;
    logic             r_row_first;
    logic [PIX_W-1:0] r_prev_pix;
    // Neighbors carried from the previous word of the row
    t_err             r_above;
    t_err             r_left;
    // Output register
    logic             r_out_valid;
    logic             r_out_dark;
    logic             r_out_eor;

    logic             take;
    logic             top;
    logic             is_a;
    logic             first_col;
    t_err             run_e;
    logic [WW-1:0]    fill_a_e;
    logic [WW-1:0]    fill_b_e;
    t_err             edge_a_e;
    t_err             edge_b_e;
    logic             row_first_e;
    logic [PIX_W-1:0] prev_pix_e;
    logic [WW-1:0]    fill_prev;
    logic [WW-1:0]    fill_cur;
    logic [WW-1:0]    fill_new;
    t_err             edge_prev;
    t_err             edge_cur;
    t_err             rd0;
    t_err             rd1;
    t_err             cur_rd1;
    logic [WW-1:0]    col_w;
    logic [WW-1:0]    col_p1;
    logic [WW-1:0]    col_m1;
    t_err             above;
    t_err             above_right;
    t_err             above_left_rd;
    t_err             left_above;
    t_err             left;
    t_sum             sum;
    t_sum             sum_adj;
    t_sum             quot;
    t_err             pix_s;
    t_err             gl;
    t_err             gl_less;
    logic             white;
    t_err             err_w;
    logic             fb;
    t_err             x_s;
    t_err             diff;
    t_err             half;
    t_err             edge_new;

    assign take = i_s1.valid && (!r_out_valid || i_out_ready);

    assign top       = i_s1.phase == PH_TOP;
    assign is_a      = i_s1.phase == PH_A;
    assign first_col = i_s1_col == '0;

    // State as seen after an image-start clear
    assign run_e       = i_s1.start ? '0 : r_run;
    assign fill_a_e    = i_s1.start ? '0 : r_fill_a;
    assign fill_b_e    = i_s1.start ? '0 : r_fill_b;
    assign edge_a_e    = i_s1.start ? '0 : r_edge_a;
    assign edge_b_e    = i_s1.start ? '0 : r_edge_b;
    assign row_first_e = i_s1.start ? 1'b0 : r_row_first;
    assign prev_pix_e  = i_s1.start ? '0 : r_prev_pix;

    // Buffer roles: row A writes a and reads b, row B and the top row write b
    assign fill_prev = is_a ? fill_b_e : fill_a_e;
    assign fill_cur  = is_a ? fill_a_e : fill_b_e;
    assign edge_prev = is_a ? edge_b_e : edge_a_e;
    assign edge_cur  = is_a ? edge_a_e : edge_b_e;
    assign rd0       = is_a ? i_b_rdata0 : i_a_rdata0;
    assign rd1       = is_a ? i_b_rdata1 : i_a_rdata1;
    assign cur_rd1   = is_a ? i_a_rdata1 : i_b_rdata1;

    // Entries past the fill mark were not written since the clear: read zero
    assign col_w         = WW'(i_s1_col);
    assign col_p1        = col_w + WW'(1);
    assign col_m1        = col_w - WW'(1);
    assign above         = (col_w < fill_prev) ? rd0 : '0;
    assign above_right   = (!i_s1.last && (col_p1 < fill_prev)) ? rd1 : '0;
    assign above_left_rd = (col_m1 < fill_prev) ? rd1 : '0;

    // A column clamped back by a lowered width takes its left neighbors
    // from the buffers, not from the previous word
    assign left_above = first_col ? edge_prev : (i_s1.rewind ? above_left_rd : r_above);
    assign left       = first_col ? edge_cur : (i_s1.rewind ? cur_rd1 : r_left);

    // Weighted sum, divided by 16 truncating toward zero
    assign sum = t_sum'(left_above) + t_sum'(5) * t_sum'(above)
               + t_sum'(3) * t_sum'(above_right) + t_sum'(7) * t_sum'(left);
    assign sum_adj = sum + (sum[15] ? t_sum'(15) : t_sum'(0));
    assign quot    = sum_adj >>> 4;

    // Threshold
    assign pix_s   = t_err'({4'b0000, i_s1.pix});
    assign gl      = top ? (pix_s + run_e) : (pix_s + t_err'(quot));
    assign white   = gl > t_err'(127);
    assign gl_less = gl - t_err'(255);

    // Error stored for this column
    always_comb begin
        if (top) begin
            err_w = white ? t_err'(-64) : t_err'(63);
        end else begin
            err_w = white ? gl_less : gl;
        end
    end

    // Left-edge entry left at the end of a later row
    assign fb       = first_col ? !white : row_first_e;
    assign x_s      = t_err'({4'b0000, prev_pix_e});
    assign diff     = t_err'(127) - x_s;
    assign half     = (diff + (diff[ERR_W-1] ? t_err'(1) : t_err'(0))) >>> 1;
    assign edge_new = x_s - (fb ? t_err'(255) : t_err'(0)) + half;

    assign fill_new = (col_p1 > fill_cur) ? col_p1 : fill_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= '0;
            r_fill_a    <= '0;
            r_fill_b    <= '0;
            r_edge_a    <= '0;
            r_edge_b    <= '0;
            r_row_first <= 1'b0;
            r_prev_pix  <= '0;
        end else if (take) begin
            // Running error of the top row
            if (top) begin
                r_run <= i_s1.last ? '0 : (white ? gl_less : gl);
            end else begin
                r_run <= run_e;
            end
            // Fill marks
            r_fill_a <= is_a ? fill_new : fill_a_e;
            r_fill_b <= is_a ? fill_b_e : fill_new;
            // Left-edge entries
            r_edge_a <= (!top && i_s1.last && is_a) ? edge_new : edge_a_e;
            r_edge_b <= (!top && i_s1.last && !is_a) ? edge_new : edge_b_e;
            r_row_first <= (!top && first_col) ? !white : row_first_e;
            r_prev_pix  <= i_s1.last ? i_s1.pix : prev_pix_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_above <= above;
            r_left  <= err_w;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_dark <= !white;
            r_out_eor  <= i_s1.last;
        end
    end

    assign o_take       = take;
    assign o_a_we       = take && is_a;
    assign o_b_we       = take && !is_a;
    assign o_waddr      = i_s1_col;
    assign o_wdata      = err_w;
    assign o_out_valid  = r_out_valid;
    assign o_dark       = r_out_dark;
    assign o_end_of_row = r_out_eor;

endmodule

// ===== sv/error_diffusion_bilevel_dither.sv =====
// Path: an accepted word is held in the input word register, then in the output register.
// Throughput: one pixel per cycle unless stalled; each line buffer has one write and two
// reads per cycle. Stalls: a waiting result lets one more word into the input register,
// then ready stays low until the result is taken.
// Reset (sync, active low): line width 512, top row, errors zero; no clearing pass,
// the buffers use fill marks, so the block accepts pixels right after reset.
module error_diffusion_bilevel_dither #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [edbd_pkg::PIX_W-1:0] i_gray_level,
    input  logic                       i_start_of_image,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_dark,
    output logic                       o_end_of_row,
    input  logic                       i_cfg_wr_en,
    input  logic [edbd_pkg::LW_W-1:0]  i_cfg_wr_data
);
    import edbd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    t_s1_ctl       s1;
    logic [CW-1:0] s1_col;
    logic          take;
    logic          rd_en;
    logic [CW-1:0] raddr0;
    logic [CW-1:0] raddr1;
    logic          a_we;
    logic          b_we;
    logic [CW-1:0] waddr;
    t_err          wdata;
    t_err          a_rdata0;
    t_err          a_rdata1;
    t_err          b_rdata0;
    t_err          b_rdata1;

    // Column and row sequencing, line width register
    edbd_seq #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_gray_level    (i_gray_level),
        .i_start_of_image(i_start_of_image),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_take          (take),
        .o_s1            (s1),
        .o_s1_col        (s1_col),
        .o_rd_en         (rd_en),
        .o_raddr0        (raddr0),
        .o_raddr1        (raddr1)
    );

    // Two error line buffers
    edbd_lmem #(
        .DEPTH(MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr0(raddr0),
        .i_raddr1(raddr1),
        .o_rdata0(a_rdata0),
        .o_rdata1(a_rdata1)
    );

    edbd_lmem #(
        .DEPTH(MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr0(raddr0),
        .i_raddr1(raddr1),
        .o_rdata0(b_rdata0),
        .o_rdata1(b_rdata1)
    );

    // Error datapath and output register
    edbd_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1        (s1),
        .i_s1_col    (s1_col),
        .i_a_rdata0  (a_rdata0),
        .i_a_rdata1  (a_rdata1),
        .i_b_rdata0  (b_rdata0),
        .i_b_rdata1  (b_rdata1),
        .i_out_ready (i_out_ready),
        .o_take      (take),
        .o_a_we      (a_we),
        .o_b_we      (b_we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_out_valid (o_out_valid),
        .o_dark      (o_dark),
        .o_end_of_row(o_end_of_row)
    );

`ifndef SYNTH
    // Only one buffer is written per word
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(a_we && b_we))
        else $error("both line buffers written in one cycle");

    // Buffer writes happen only when a word leaves the datapath stage
    a_write_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_we || b_we) |-> (take && s1.valid))
        else $error("line buffer written without a word in the datapath");

    // An empty output register never holds off the input side
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output register");
`endif

endmodule

// ===== test/tb_error_diffusion_bilevel_dither.sv =====
module tb_error_diffusion_bilevel_dither;
    timeunit 1ns;
    timeprecision 1ps;

    import edbd_pkg::*;

    localparam int MAX_W = 512;
    localparam int LIMIT_NS = 50_000_000;

    // One output word: dithered bit plus row marker
    typedef struct packed {
        logic dark;
        logic eor;
    } t_dither_word;

    // Tracks the dither state and the words still owed by the block
    class dither_scoreboard;
        logic [LW_W-1:0] width_reg;
        int              err_line [2][MAX_W+2];   // [0] is line a, [1] is line b
        int              row_err;
        int              col;
        t_phase          phase;
        int              last_pix;
        bit              first_dark;
        t_dither_word    words_due[$];
        int              mismatches;

        function new();
            width_reg  = LW_RESET;
            mismatches = 0;
            clear_image();
        endfunction

        function void clear_image();
            foreach (err_line[i, j]) err_line[i][j] = 0;
            row_err    = 0;
            col        = 0;
            phase      = PH_TOP;
            last_pix   = 0;
            first_dark = 1'b0;
        endfunction

        function void set_width(logic [LW_W-1:0] w);
            width_reg = w;
        endfunction

        function int pending();
            return words_due.size();
        endfunction

        // Accepted pixel: advance the state and queue the word it produces
        function void add_pixel(logic [PIX_W-1:0] gray, logic soi);
            int           pix, w, c, gl, sum, ra, cur, prv;
            bit           last, white;
            t_dither_word word;
            pix = int'(gray);
            if (soi) clear_image();
            w = int'(width_reg);
            if (w == 0) w = 1;
            if (w > MAX_W) w = MAX_W;
            c = col;
            if (c >= w) c = w - 1;
            last = (c + 1 >= w);
            cur  = (phase == PH_A) ? 0 : 1;
            prv  = 1 - cur;

            if (phase == PH_TOP) begin
                gl      = pix + row_err;
                white   = gl > 127;
                row_err = gl - (white ? 255 : 0);
                err_line[1][c+1] = white ? -64 : 63;
            end else begin
                ra    = last ? 0 : err_line[prv][c+2];
                sum   = err_line[prv][c] + 5 * err_line[prv][c+1] + 3 * ra
                        + 7 * err_line[cur][c];
                gl    = pix + sum / 16;
                white = gl > 127;
                err_line[cur][c+1] = white ? gl - 255 : gl;
                if (c == 0) first_dark = !white;
            end

            // Row end: left-edge entry, buffer swap
            if (last) begin
                if (phase == PH_TOP) begin
                    row_err = 0;
                    phase   = PH_A;
                end else begin
                    err_line[cur][0] = last_pix - (first_dark ? 255 : 0)
                                       + (127 - last_pix) / 2;
                    phase = (phase == PH_A) ? PH_B : PH_A;
                end
                last_pix = pix;
                col      = 0;
            end else begin
                col = c + 1;
            end

            word.dark = !white;
            word.eor  = last;
            words_due.push_back(word);
        endfunction

        // Accepted output word: compare with the oldest one owed
        function void check_word(logic dark, logic eor);
            t_dither_word exp_w;
            if (words_due.size() == 0) begin
                $display("%0t: unexpected word dark=%0b end_of_row=%0b", $time, dark, eor);
                mismatches++;
                return;
            end
            exp_w = words_due.pop_front();
            if (dark !== exp_w.dark) begin
                $display("%0t: dark expected %0b actual %0b", $time, exp_w.dark, dark);
                mismatches++;
            end
            if (eor !== exp_w.eor) begin
                $display("%0t: end_of_row expected %0b actual %0b", $time, exp_w.eor, eor);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    logic [PIX_W-1:0] gray        = '0;
    logic             soi_in      = 1'b0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    logic             dark;
    logic             end_of_row;
    logic             cfg_wr_en   = 1'b0;
    logic [LW_W-1:0]  cfg_wr_data = '0;

    dither_scoreboard sb;
    bit               idle_on = 1'b1;

    error_diffusion_bilevel_dither #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_gray_level    (gray),
        .i_start_of_image(soi_in),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_dark          (dark),
        .o_end_of_row    (end_of_row),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure while idle_on is set, else always ready
    initial begin
        forever begin
            @(posedge clk);
            out_ready <= idle_on ? ($urandom_range(99) >= 36) : 1'b1;
        end
    end

    // Sample at the falling edge; an accepted word is settled until the next rise
    initial begin
        forever begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready) sb.check_word(dark, end_of_row);
        end
    end

    // Send one pixel word and hold it until taken
    task automatic send_pixel(input logic [PIX_W-1:0] g, input logic soi);
        bit took;
        if (idle_on && $urandom_range(99) < 36) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        gray     <= g;
        soi_in   <= soi;
        do begin
            @(negedge clk);
            took = in_ready;
            if (took) sb.add_pixel(g, soi);
            @(posedge clk);
        end while (!took);
    endtask

    // Stop sending and wait for every owed word
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_width(input logic [LW_W-1:0] w);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_width(w);
    endtask

    // Bias toward threshold and range ends
    function automatic logic [PIX_W-1:0] pick_gray();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int n_rand, w, ew, npix, r, k;
        bit new_img, soi;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: thresholds, row ends, left edge, mid-row width drop
        write_width(10'd4);
        send_pixel(8'd0, 1'b1);   send_pixel(8'd255, 1'b0);
        send_pixel(8'd127, 1'b0); send_pixel(8'd128, 1'b0);
        send_pixel(8'd255, 1'b0); send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0); send_pixel(8'd127, 1'b0);
        send_pixel(8'd200, 1'b0); send_pixel(8'd60, 1'b0);
        send_pixel(8'd130, 1'b0); send_pixel(8'd90, 1'b0);
        send_pixel(8'd10, 1'b0);  send_pixel(8'd250, 1'b0);
        write_width(10'd2);       // column 2 is past the new last column
        send_pixel(8'd77, 1'b0);  send_pixel(8'd180, 1'b0);
        write_width(10'd1);
        send_pixel(8'd255, 1'b1); send_pixel(8'd0, 1'b0);
        send_pixel(8'd128, 1'b0); send_pixel(8'd127, 1'b0);
        write_width(10'd0);       // acts as one
        send_pixel(8'd64, 1'b0);  send_pixel(8'd192, 1'b0);
        send_pixel(8'd0, 1'b1);

        // Widest rows: oversized width clamps to the maximum
        write_width(10'd1023);
        for (k = 0; k < MAX_W + 16; k++) send_pixel(pick_gray(), k == 0);
        write_width(10'd512);
        for (k = 0; k < 8; k++) send_pixel(pick_gray(), 1'b0);
        write_width(10'd6);
        for (k = 0; k < 12; k++) send_pixel(pick_gray(), 1'b0);

        // Random images of small width, some rows left partial
        n_rand = 0;
        while (n_rand < 830) begin
            r = $urandom_range(99);
            if (r < 6)       w = 0;
            else if (r < 12) w = 1;
            else             w = $urandom_range(2, 24);
            write_width(LW_W'(w));
            ew      = (w == 0) ? 1 : w;
            npix    = ew * $urandom_range(1, 5);
            if ($urandom_range(3) == 0) npix += $urandom_range(0, ew - 1);
            new_img = ($urandom_range(99) < 60);
            for (k = 0; k < npix; k++) begin
                idle_on = !(n_rand >= 300 && n_rand < 600);
                soi     = (k == 0 && new_img) || ($urandom_range(99) < 2);
                send_pixel(pick_gray(), soi);
                n_rand++;
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
